// ----- rtl/bset_pkg.sv -----
`timescale 1ns / 1ps

package bset_pkg;

    localparam int SIZE_W = 13;
    localparam int ITER_W = 10;
    localparam int EXP_W = 4;
    localparam int INTENSITY_W = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 13;
    localparam int DIV_W = 20;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_SIZE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_ITER = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_EXPONENT = 2'd2;

    localparam logic [SIZE_W-1:0] RST_IMAGE_SIZE = 13'd512;
    localparam logic [ITER_W-1:0] RST_MAX_ITER = 10'd255;
    localparam logic [EXP_W-1:0] RST_EXPONENT = 4'd2;

    // multiplier operand selects
    localparam logic [1:0] OPA_ZR = 2'd0;
    localparam logic [1:0] OPA_ZI = 2'd1;
    localparam logic [1:0] OPA_WR = 2'd2;
    localparam logic [1:0] OPA_WI = 2'd3;
    localparam logic [1:0] OPB_ZR = 2'd0;
    localparam logic [1:0] OPB_ZI = 2'd1;
    localparam logic [1:0] OPB_X = 2'd2;
    localparam logic [1:0] OPB_Y = 2'd3;

    localparam logic [1:0] ACC_HOLD = 2'd0;
    localparam logic [1:0] ACC_LOAD = 2'd1;
    localparam logic [1:0] ACC_ADD = 2'd2;
    localparam logic [1:0] ACC_SUB = 2'd3;

    localparam logic [1:0] DIV_COL = 2'd0;
    localparam logic [1:0] DIV_ROW = 2'd1;
    localparam logic [1:0] DIV_INTENSITY = 2'd2;

    typedef struct packed {
        logic       capture_in;
        logic       div_load;
        logic [1:0] div_sel;
        logic       div_step;
        logic       coord_store;
        logic       coord_row;
        logic       z_init;
        logic [1:0] a_sel;
        logic [1:0] b_sel;
        logic [1:0] acc_op;
        logic       pow_init;
        logic       tmp_store;
        logic       pow_finish;
        logic       z_update;
        logic       out_load;
    } bset_cmd_t;

    typedef struct packed {
        logic below_limit;
        logic escaped;
        logic more_power;
        logic out_free;
    } bset_status_t;

endpackage

// ----- rtl/bset_datapath.sv -----
`timescale 1ns / 1ps

module bset_datapath #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS = 28
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [COORD_BITS-1:0]              pixel_column,
    input  logic [COORD_BITS-1:0]              pixel_row,
    input  logic                               cfg_write,
    input  logic [bset_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bset_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  bset_pkg::bset_cmd_t                cmd,
    output bset_pkg::bset_status_t             status,
    input  logic                               out_stall,
    output logic                               out_valid,
    output logic [bset_pkg::INTENSITY_W-1:0]   intensity,
    output logic [bset_pkg::ITER_W-1:0]        iterations_done
);
    import bset_pkg::*;

    localparam int W = FRAC_BITS + 4;
    localparam logic signed [W-1:0] QMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] QMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [W+3:0] QLIM_EXT = (W+4)'(1) << (W-1);
    localparam logic [63:0] ORIGIN64 = ((64'd22 << FRAC_BITS) + 64'd5) / 64'd10;
    localparam logic [W-1:0] ORIGIN = ORIGIN64[W-1:0];
    localparam logic signed [W:0] ESCAPE = (W+1)'(4) << FRAC_BITS;
    localparam logic signed [W-1:0] ONE = W'(1) << FRAC_BITS;

    function automatic logic signed [W-1:0] sat_w(input logic signed [W:0] v);
        if (v > $signed({QMAX[W-1], QMAX}))
            return QMAX;
        else if (v < $signed({QMIN[W-1], QMIN}))
            return QMIN;
        else
            return v[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] abs_w(input logic signed [W-1:0] v);
        if (v == QMIN)
            return QMAX;
        else if (v < 0)
            return -v;
        else
            return v;
    endfunction

    logic [SIZE_W-1:0]     size_reg;
    logic [ITER_W-1:0]     max_reg;
    logic [EXP_W-1:0]      exp_reg;
    logic [COORD_BITS-1:0] col_reg, row_reg;
    logic [DIV_W-1:0]      r_reg, r_next, dsh_reg, dsh_next, r_sub;
    logic [W-1:0]          q_reg, q_next;
    logic                  ovf_reg, ovf_next, qbit;
    logic signed [W-1:0]   cr_reg, ci_reg, zr_reg, zi_reg, x_reg, y_reg;
    logic signed [W-1:0]   wr_reg, wi_reg, tmp_reg;
    logic signed [W:0]     acc_reg, acc_next;
    logic [2*W-1:0]        prod_reg, prod_next;
    logic                  neg_reg, neg_next;
    logic [ITER_W-1:0]     count_reg;
    logic [EXP_W-1:0]      k_reg;
    logic                  out_valid_reg;
    logic [INTENSITY_W-1:0] intensity_reg;
    logic [ITER_W-1:0]     iters_reg;

    logic [SIZE_W-1:0]     size_eff;
    logic [SIZE_W:0]       dval;
    logic [COORD_BITS-1:0] idx;
    logic [DIV_W-1:0]      n_coord, n_int;
    logic signed [W-1:0]   a_val, b_val, m_val, x_new, y_new, coord_val;
    logic [W-1:0]          mag_a, mag_b, mag;
    logic [W+3:0]          hi_part;
    logic signed [W:0]     coord_diff;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= RST_IMAGE_SIZE;
            max_reg <= RST_MAX_ITER;
            exp_reg <= RST_EXPONENT;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_IMAGE_SIZE: size_reg <= cfg_data[SIZE_W-1:0];
                REG_MAX_ITER:   max_reg <= cfg_data[ITER_W-1:0];
                REG_EXPONENT:   exp_reg <= cfg_data[EXP_W-1:0];
                default:        ;
            endcase
        end
    end

    // shared restoring divider
    always_comb
    begin
        size_eff = (size_reg == '0) ? SIZE_W'(1) : size_reg;
        dval = {size_eff, 1'b0};
        idx = cmd.div_sel == DIV_ROW ? row_reg : col_reg;
        n_coord = (DIV_W'(idx) << 3) - DIV_W'(idx);
        n_int = (DIV_W'(count_reg) << 8) - DIV_W'(count_reg);
        qbit = r_reg >= dsh_reg;
        r_sub = qbit ? r_reg - dsh_reg : r_reg;
        r_next = r_reg;
        dsh_next = dsh_reg;
        q_next = q_reg;
        ovf_next = ovf_reg;
        if (cmd.div_load)
        begin
            q_next = '0;
            if (cmd.div_sel == DIV_INTENSITY)
            begin
                r_next = n_int;
                dsh_next = DIV_W'(max_reg) << 7;
                ovf_next = 1'b0;
            end
            else
            begin
                r_next = n_coord;
                dsh_next = DIV_W'(dval) << 3;
                ovf_next = n_coord >= (DIV_W'(dval) << 4);
            end
        end
        else if (cmd.div_step)
        begin
            r_next = r_sub << 1;
            q_next = {q_reg[W-2:0], qbit};
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
        dsh_reg <= dsh_next;
        q_reg <= q_next;
        ovf_reg <= ovf_next;
    end

    always_comb
    begin
        coord_diff = $signed({1'b0, q_reg}) - $signed({1'b0, ORIGIN});
        coord_val = ovf_reg ? QMAX : sat_w(coord_diff);
    end

    // multiplier
    always_comb
    begin
        case (cmd.a_sel)
            OPA_ZR:  a_val = zr_reg;
            OPA_ZI:  a_val = zi_reg;
            OPA_WR:  a_val = wr_reg;
            default: a_val = wi_reg;
        endcase
        case (cmd.b_sel)
            OPB_ZR:  b_val = zr_reg;
            OPB_ZI:  b_val = zi_reg;
            OPB_X:   b_val = x_reg;
            default: b_val = y_reg;
        endcase
        mag_a = a_val[W-1] ? W'(-a_val) : W'(a_val);
        mag_b = b_val[W-1] ? W'(-b_val) : W'(b_val);
        prod_next = (2*W)'(mag_a) * (2*W)'(mag_b);
        neg_next = a_val[W-1] ^ b_val[W-1];
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        neg_reg <= neg_next;
    end

    always_comb
    begin
        hi_part = prod_reg[2*W-1:FRAC_BITS];
        mag = (hi_part > QLIM_EXT) ? QLIM_EXT[W-1:0] : hi_part[W-1:0];
        if (neg_reg)
            m_val = -$signed(mag);
        else if (mag > W'(QMAX))
            m_val = QMAX;
        else
            m_val = $signed(mag);
        case (cmd.acc_op)
            ACC_LOAD: acc_next = (W+1)'(m_val);
            ACC_ADD:  acc_next = acc_reg + (W+1)'(m_val);
            ACC_SUB:  acc_next = acc_reg - (W+1)'(m_val);
            default:  acc_next = acc_reg;
        endcase
        x_new = abs_w(zr_reg);
        y_new = abs_w(zi_reg);
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (cmd.capture_in)
        begin
            col_reg <= pixel_column;
            row_reg <= pixel_row;
        end
        if (cmd.coord_store)
        begin
            if (cmd.coord_row)
                ci_reg <= coord_val;
            else
                cr_reg <= coord_val;
        end
        if (cmd.z_init)
        begin
            zr_reg <= '0;
            zi_reg <= '0;
            count_reg <= '0;
        end
        else if (cmd.z_update)
        begin
            zr_reg <= sat_w((W+1)'(wr_reg) + (W+1)'(cr_reg));
            zi_reg <= sat_w((W+1)'(wi_reg) + (W+1)'(ci_reg));
            count_reg <= count_reg + ITER_W'(1);
        end
        if (cmd.pow_init)
        begin
            x_reg <= x_new;
            y_reg <= y_new;
            k_reg <= EXP_W'(1);
            if (exp_reg == '0)
            begin
                wr_reg <= ONE;
                wi_reg <= '0;
            end
            else
            begin
                wr_reg <= x_new;
                wi_reg <= y_new;
            end
        end
        else if (cmd.pow_finish)
        begin
            wr_reg <= tmp_reg;
            wi_reg <= sat_w(acc_reg);
            k_reg <= k_reg + EXP_W'(1);
        end
        if (cmd.tmp_store)
            tmp_reg <= sat_w(acc_reg);
        if (cmd.out_load)
        begin
            intensity_reg <= (max_reg == '0) ? '0 : q_reg[INTENSITY_W-1:0];
            iters_reg <= count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    assign status.below_limit = count_reg < max_reg;
    assign status.escaped = acc_reg >= ESCAPE;
    assign status.more_power = k_reg < exp_reg;
    assign status.out_free = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign intensity = intensity_reg;
    assign iterations_done = iters_reg;

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.z_update |=> count_reg == $past(count_reg) + ITER_W'(1))
        else $error("iteration count did not advance");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !out_valid_reg || !out_stall)
        else $error("result register overwritten while stalled");

    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> count_reg <= max_reg)
        else $error("iteration count above limit");

endmodule

// ----- rtl/bset_ctrl.sv -----
`timescale 1ns / 1ps

module bset_ctrl #(
    parameter int FRAC_BITS = 28
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  bset_pkg::bset_status_t status,
    output bset_pkg::bset_cmd_t    cmd
);
    import bset_pkg::*;

    localparam int W = FRAC_BITS + 4;
    localparam int SW = $clog2(W);

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_DLOAD = 5'd1;
    localparam logic [4:0] ST_DSTEP = 5'd2;
    localparam logic [4:0] ST_DSTORE = 5'd3;
    localparam logic [4:0] ST_ZINIT = 5'd4;
    localparam logic [4:0] ST_CHK = 5'd5;
    localparam logic [4:0] ST_SQ1 = 5'd6;
    localparam logic [4:0] ST_SQ1A = 5'd7;
    localparam logic [4:0] ST_SQ2 = 5'd8;
    localparam logic [4:0] ST_SQ2A = 5'd9;
    localparam logic [4:0] ST_TEST = 5'd10;
    localparam logic [4:0] ST_PCHK = 5'd11;
    localparam logic [4:0] ST_P1 = 5'd12;
    localparam logic [4:0] ST_P1A = 5'd13;
    localparam logic [4:0] ST_P2 = 5'd14;
    localparam logic [4:0] ST_P2A = 5'd15;
    localparam logic [4:0] ST_P3 = 5'd16;
    localparam logic [4:0] ST_P3A = 5'd17;
    localparam logic [4:0] ST_P4 = 5'd18;
    localparam logic [4:0] ST_P4A = 5'd19;
    localparam logic [4:0] ST_P5 = 5'd20;
    localparam logic [4:0] ST_UPD = 5'd21;
    localparam logic [4:0] ST_FIN = 5'd22;
    localparam logic [4:0] ST_ISTEP = 5'd23;
    localparam logic [4:0] ST_OUT = 5'd24;

    logic [4:0]    state_reg, state_next;
    logic [SW-1:0] step_reg, step_next;
    logic [1:0]    dsel_reg, dsel_next;

    always_comb
    begin
        state_next = state_reg;
        step_next = step_reg;
        dsel_next = dsel_reg;
        cmd = '0;
        cmd.div_sel = dsel_reg;
        cmd.coord_row = dsel_reg == DIV_ROW;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture_in = 1'b1;
                    dsel_next = DIV_COL;
                    state_next = ST_DLOAD;
                end
            end
            ST_DLOAD:
            begin
                cmd.div_load = 1'b1;
                step_next = SW'(W - 1);
                state_next = ST_DSTEP;
            end
            ST_DSTEP:
            begin
                cmd.div_step = 1'b1;
                step_next = step_reg - SW'(1);
                if (step_reg == '0)
                    state_next = ST_DSTORE;
            end
            ST_DSTORE:
            begin
                cmd.coord_store = 1'b1;
                if (dsel_reg == DIV_COL)
                begin
                    dsel_next = DIV_ROW;
                    state_next = ST_DLOAD;
                end
                else
                    state_next = ST_ZINIT;
            end
            ST_ZINIT:
            begin
                cmd.z_init = 1'b1;
                state_next = ST_CHK;
            end
            ST_CHK:
                state_next = status.below_limit ? ST_SQ1 : ST_FIN;
            ST_SQ1:
            begin
                cmd.a_sel = OPA_ZR;
                cmd.b_sel = OPB_ZR;
                state_next = ST_SQ1A;
            end
            ST_SQ1A:
            begin
                cmd.acc_op = ACC_LOAD;
                state_next = ST_SQ2;
            end
            ST_SQ2:
            begin
                cmd.a_sel = OPA_ZI;
                cmd.b_sel = OPB_ZI;
                state_next = ST_SQ2A;
            end
            ST_SQ2A:
            begin
                cmd.acc_op = ACC_ADD;
                state_next = ST_TEST;
            end
            ST_TEST:
            begin
                if (status.escaped)
                    state_next = ST_FIN;
                else
                begin
                    cmd.pow_init = 1'b1;
                    state_next = ST_PCHK;
                end
            end
            ST_PCHK:
                state_next = status.more_power ? ST_P1 : ST_UPD;
            ST_P1:
            begin
                cmd.a_sel = OPA_WR;
                cmd.b_sel = OPB_X;
                state_next = ST_P1A;
            end
            ST_P1A:
            begin
                cmd.acc_op = ACC_LOAD;
                state_next = ST_P2;
            end
            ST_P2:
            begin
                cmd.a_sel = OPA_WI;
                cmd.b_sel = OPB_Y;
                state_next = ST_P2A;
            end
            ST_P2A:
            begin
                cmd.acc_op = ACC_SUB;
                state_next = ST_P3;
            end
            ST_P3:
            begin
                cmd.tmp_store = 1'b1;
                cmd.a_sel = OPA_WR;
                cmd.b_sel = OPB_Y;
                state_next = ST_P3A;
            end
            ST_P3A:
            begin
                cmd.acc_op = ACC_LOAD;
                state_next = ST_P4;
            end
            ST_P4:
            begin
                cmd.a_sel = OPA_WI;
                cmd.b_sel = OPB_X;
                state_next = ST_P4A;
            end
            ST_P4A:
            begin
                cmd.acc_op = ACC_ADD;
                state_next = ST_P5;
            end
            ST_P5:
            begin
                cmd.pow_finish = 1'b1;
                state_next = ST_PCHK;
            end
            ST_UPD:
            begin
                cmd.z_update = 1'b1;
                state_next = ST_CHK;
            end
            ST_FIN:
            begin
                cmd.div_load = 1'b1;
                cmd.div_sel = DIV_INTENSITY;
                dsel_next = DIV_INTENSITY;
                step_next = SW'(INTENSITY_W - 1);
                state_next = ST_ISTEP;
            end
            ST_ISTEP:
            begin
                cmd.div_step = 1'b1;
                step_next = step_reg - SW'(1);
                if (step_reg == '0)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg <= '0;
            dsel_reg <= DIV_COL;
        end
        else
        begin
            state_reg <= state_next;
            step_reg <= step_next;
            dsel_reg <= dsel_next;
        end
    end

    assign in_stall = state_reg != ST_IDLE;

    a_div_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DLOAD) |=> state_reg == ST_DSTEP && step_reg == SW'(W - 1))
        else $error("divider step count not loaded");

    a_power_guard: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_P1) |-> $past(state_reg) == ST_PCHK && $past(status.more_power))
        else $error("power step entered without pending factor");

    a_store_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.coord_store |-> $past(cmd.div_step) && $past(step_reg) == '0)
        else $error("coordinate stored before division finished");

endmodule

// ----- rtl/burning_ship_escape_time.sv -----
`timescale 1ns / 1ps

// Burning Ship escape-time evaluator for one pixel per transaction. The pixel
// position is mapped to c in signed fixed point (FRAC_BITS fraction bits, range
// [-8, 8)), then z <- (|Re z| + i|Im z|)^exponent + c is iterated until
// |z|^2 >= 4 or max_iterations is reached; the result carries the count and
// 255*count/max_iterations. All products go through one shared, registered
// multiplier, and every division runs on one bit-serial divider. A pixel
// first divides out its column and row, then iterates, then divides out the
// intensity; one pixel is in work at a time, and a finished result waits in
// the output register while the next pixel is taken. Configuration must be
// written only while no transaction is in progress; the block itself does
// not enforce this.
module burning_ship_escape_time #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS = 28
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [COORD_BITS-1:0]             pixel_column,
    input  logic [COORD_BITS-1:0]             pixel_row,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [bset_pkg::INTENSITY_W-1:0]  intensity,
    output logic [bset_pkg::ITER_W-1:0]       iterations_done,
    input  logic                              cfg_write,
    input  logic [bset_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bset_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import bset_pkg::*;

    bset_cmd_t    cmd;
    bset_status_t status;

    bset_ctrl #(
        .FRAC_BITS(FRAC_BITS)
    ) u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .status(status),
        .cmd(cmd)
    );

    bset_datapath #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS(FRAC_BITS)
    ) u_datapath (
        .clk(clk),
        .rst_n(rst_n),
        .pixel_column(pixel_column),
        .pixel_row(pixel_row),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .cmd(cmd),
        .status(status),
        .out_stall(out_stall),
        .out_valid(out_valid),
        .intensity(intensity),
        .iterations_done(iterations_done)
    );

endmodule
